### src/assert_macros.svh
// Assertion macros used by the timer queue top level.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge outside reset.
`define STQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/stq_pkg.sv
// Types and codes for the sorted timeout queue.
// Used by stq_cell and sorted_timeout_queue; no dependencies.
package stq_pkg;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_REARM  = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_STOPPED  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DROP = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [39:0] deadline;
    logic [23:0] period;
    logic        rep;
  } slot_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] key;
    slot_t      ent;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [23:0] rem;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

### src/sorted_timeout_queue.sv
// Sorted timeout queue: top level with the slot chain and command sequencer.
// Depends on stq_pkg, stq_cell and assert_macros.svh.
//
// Commands arrive on in_valid/in_ready with cmd, timer_id, period_ms,
// repeat_flag and step_ms; one command is in work at a time. Results leave
// on out_valid/out_ready through one output register; last_of_run marks the
// final result of a command. cfg_we writes run_enable from cfg_wdata.
// Add goes exec, alloc (which skips each id already in use), insert, load.
// Read, any miss, a full add and a stopped tick go from exec to load;
// remove goes find, drop, load; re-arm goes find, drop, insert, load.
// A tick with nothing due ends after its check; otherwise each expiry
// goes check, drop, insert for a repeating timer, check, load, with at
// most MAX_FIRES_PER_TICK. Each shift or search spans all TIMER_SLOTS cells.
// A new command is taken in the cycle after the last result is loaded,
// even while that result still waits. When the receiver stalls, the
// sequencer waits at its next result and holds all state.
// Reset empties the table, clears the clock and run_enable, and sets the
// next id to one.
module sorted_timeout_queue import stq_pkg::*; #(
  parameter int TIMER_SLOTS        = 16,
  parameter int MAX_FIRES_PER_TICK = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  timer_id,
  input  logic [23:0] period_ms,
  input  logic        repeat_flag,
  input  logic [15:0] step_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  result_id,
  output logic [23:0] remaining_ms,
  output logic [1:0]  status,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  `include "assert_macros.svh"

  localparam int FW = $clog2(MAX_FIRES_PER_TICK + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_ALLOC = 7'b0000100,
    S_DROP  = 7'b0001000,
    S_INS   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_TCHK  = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic        run_enable;
  logic [39:0] clock_ms, clock_ms_next;
  logic [7:0]  nfi, nfi_next;
  logic [2:0]  cmd_r;
  logic [7:0]  id_r;
  logic [23:0] period_r;
  logic        rep_r;
  logic [15:0] step_r;
  slot_t       ins, ins_next;
  logic [7:0]  key, key_next;
  logic        do_ins, do_ins_next;
  logic        tick_mode, tick_mode_next;
  logic        have_pend, have_pend_next;
  logic [FW-1:0] fires, fires_next;
  result_t     res, res_next, out_q;
  logic        out_free;

  cell_ctrl_t  ctrl;
  slot_t       slots [TIMER_SLOTS];
  logic        ge    [TIMER_SLOTS];
  logic        hit   [TIMER_SLOTS];
  logic        match [TIMER_SLOTS];

  localparam slot_t SLOT_EMPTY = '0;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    slot_t lft, rgt;
    logic  lge, hin;
    if (i == 0) begin : g_first
      assign lft = SLOT_EMPTY;
      assign lge = 1'b0;
      assign hin = 1'b0;
    end else begin : g_mid
      assign lft = slots[i-1];
      assign lge = ge[i-1];
      assign hin = hit[i-1];
    end
    if (i == TIMER_SLOTS - 1) begin : g_last
      assign rgt = SLOT_EMPTY;
    end else begin : g_inner
      assign rgt = slots[i+1];
    end
    stq_cell u_cell (
      .clk(clk), .rst(rst), .ctrl(ctrl), .left(lft), .left_ge(lge), .right(rgt),
      .hit_in(hin), .slot(slots[i]), .ge_out(ge[i]), .hit_out(hit[i]), .match(match[i])
    );
  end

  slot_t       msel;
  logic [39:0] rem_diff;
  logic [7:0]  cand;
  logic        full, due;

  always_comb begin
    msel = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (match[i]) msel = msel | slots[i];
    end
  end

  assign full     = slots[TIMER_SLOTS-1].valid;
  assign cand     = (nfi == 8'd0) ? 8'd1 : nfi;
  assign rem_diff = (msel.deadline > clock_ms) ? (msel.deadline - clock_ms) : 40'd0;
  assign due      = (fires < FW'(MAX_FIRES_PER_TICK)) && slots[0].valid &&
                    (slots[0].deadline < clock_ms);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    clock_ms_next  = clock_ms;
    nfi_next       = nfi;
    ins_next       = ins;
    key_next       = key;
    do_ins_next    = do_ins;
    tick_mode_next = tick_mode;
    have_pend_next = have_pend;
    fires_next     = fires;
    res_next       = res;
    ctrl.op        = OP_HOLD;
    ctrl.key       = key;
    ctrl.ent       = ins;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
        key_next       = timer_id;
        tick_mode_next = 1'b0;
        have_pend_next = 1'b0;
        do_ins_next    = 1'b0;
        fires_next     = '0;
      end
      S_EXEC: begin
        res_next = '{kind: cmd_r, id: id_r, rem: 24'd0, status: ST_OK, last: 1'b1};
        case (cmd_r)
          CMD_ADD: begin
            if (full) begin
              res_next.id     = 8'd0;
              res_next.status = ST_FULL;
              state_next      = S_EMIT;
            end else begin
              state_next = S_ALLOC;
            end
          end
          CMD_REMOVE, CMD_READ, CMD_REARM: begin
            state_next = S_EMIT;
            if (!hit[TIMER_SLOTS-1]) begin
              res_next.status = ST_NOT_FOUND;
            end else if (cmd_r == CMD_READ) begin
              res_next.rem = (|rem_diff[39:24]) ? 24'hFFFFFF : rem_diff[23:0];
            end else begin
              state_next     = S_DROP;
              do_ins_next    = (cmd_r == CMD_REARM);
              ins_next       = msel;
              ins_next.id    = id_r;
              ins_next.deadline = clock_ms + 40'(msel.period);
            end
          end
          CMD_TICK: begin
            if (!run_enable) begin
              res_next.id     = 8'd0;
              res_next.status = ST_STOPPED;
              state_next      = S_EMIT;
            end else begin
              clock_ms_next  = clock_ms + 40'(step_r);
              tick_mode_next = 1'b1;
              state_next     = S_TCHK;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ALLOC: begin
        ctrl.key = cand;
        nfi_next = cand + 8'd1;
        if (!hit[TIMER_SLOTS-1]) begin
          ins_next    = '{valid: 1'b1, id: cand, deadline: clock_ms + 40'(period_r),
                          period: period_r, rep: rep_r};
          res_next.id = cand;
          do_ins_next = 1'b1;
          state_next  = S_INS;
        end
      end
      S_DROP: begin
        ctrl.op    = OP_DROP;
        state_next = do_ins ? S_INS : (tick_mode ? S_TCHK : S_EMIT);
      end
      S_INS: begin
        ctrl.op    = OP_INS;
        state_next = tick_mode ? S_TCHK : S_EMIT;
      end
      S_TCHK: begin
        if (have_pend) begin
          res_next.last = !due;
          state_next    = S_EMIT;
        end else if (due) begin
          res_next = '{kind: CMD_TICK, id: slots[0].id, rem: 24'd0, status: ST_OK,
                       last: 1'b1};
          have_pend_next = 1'b1;
          fires_next     = fires + FW'(1);
          key_next       = slots[0].id;
          ins_next       = slots[0];
          ins_next.deadline = slots[0].deadline + 40'(slots[0].period);
          do_ins_next    = slots[0].rep;
          state_next     = S_DROP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          have_pend_next = 1'b0;
          state_next     = (tick_mode && !res.last) ? S_TCHK : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_enable <= 1'b0;
      clock_ms   <= 40'd0;
      nfi        <= 8'd1;
      out_valid  <= 1'b0;
      tick_mode  <= 1'b0;
      have_pend  <= 1'b0;
      do_ins     <= 1'b0;
      fires      <= '0;
    end else begin
      state     <= state_next;
      clock_ms  <= clock_ms_next;
      nfi       <= nfi_next;
      tick_mode <= tick_mode_next;
      have_pend <= have_pend_next;
      do_ins    <= do_ins_next;
      fires     <= fires_next;
      if (cfg_we) run_enable <= cfg_wdata;
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins <= ins_next;
    key <= key_next;
    res <= res_next;
    if (state == S_EMIT && out_free) out_q <= res;
    if (state == S_IDLE && in_valid) begin
      cmd_r    <= cmd;
      id_r     <= timer_id;
      period_r <= period_ms;
      rep_r    <= repeat_flag;
      step_r   <= step_ms;
    end
  end

  assign result_kind  = out_q.kind;
  assign result_id    = out_q.id;
  assign remaining_ms = out_q.rem;
  assign status       = out_q.status;
  assign last_of_run  = out_q.last;

  for (genvar i = 0; i + 1 < TIMER_SLOTS; i++) begin : g_chk
    `STQ_ASSERT_IMP(a_prefix, slots[i+1].valid, slots[i].valid, "valid slots not a prefix")
    `STQ_ASSERT_IMP(a_sorted, slots[i+1].valid, slots[i].deadline <= slots[i+1].deadline,
                    "slots out of deadline order")
  end
  `STQ_ASSERT(a_fire_cap, fires <= FW'(MAX_FIRES_PER_TICK), "expiry count over cap")

endmodule

### src/stq_cell.sv
// One slot of the deadline-ordered timer chain.
// Depends on stq_pkg; shifts right on insert, left on drop.
module stq_cell import stq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  slot_t      left,
  input  logic       left_ge,
  input  slot_t      right,
  input  logic       hit_in,
  output slot_t      slot,
  output logic       ge_out,
  output logic       hit_out,
  output logic       match
);

  slot_t slot_next;

  always_comb begin
    match     = slot.valid && (slot.id == ctrl.key);
    hit_out   = hit_in | match;
    ge_out    = !slot.valid || (slot.deadline >= ctrl.ent.deadline);
    slot_next = slot;
    case (ctrl.op)
      OP_INS: begin
        if (left_ge) begin
          slot_next = left;
        end else if (ge_out) begin
          slot_next       = ctrl.ent;
          slot_next.valid = 1'b1;
        end
      end
      OP_DROP: begin
        if (hit_out) slot_next = right;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule
